// ===== src/dbsc_pkg.sv =====
// Package with shared types, op codes and constants of the debug run-control unit.
package dbsc_pkg;

  localparam int BP_SLOTS_DEF = 16;
  localparam int WORD_W = 16;
  localparam int CNT_W32 = 32;
  localparam int OP_W = 4;

  localparam logic [WORD_W-1:0] WORD_MAX = 16'hffff;

  localparam logic [OP_W-1:0] OP_FETCH = 4'd0;
  localparam logic [OP_W-1:0] OP_RETIRE = 4'd1;
  localparam logic [OP_W-1:0] OP_SUB_ENTER = 4'd2;
  localparam logic [OP_W-1:0] OP_SUB_EXIT = 4'd3;
  localparam logic [OP_W-1:0] OP_ADD_BP = 4'd4;
  localparam logic [OP_W-1:0] OP_REMOVE_BP = 4'd5;
  localparam logic [OP_W-1:0] OP_RUN = 4'd6;
  localparam logic [OP_W-1:0] OP_RUN_FOR = 4'd7;
  localparam logic [OP_W-1:0] OP_STEP_OVER = 4'd8;
  localparam logic [OP_W-1:0] OP_STEP_OUT = 4'd9;

  typedef struct packed {
    logic              ident_mode;
    logic [WORD_W-1:0] key;
    logic              load;
    logic              shift;
    logic [WORD_W-1:0] ld_addr;
    logic [WORD_W-1:0] ld_ident;
  } cell_ctrl_t;

  typedef struct packed {
    logic              found;
    logic [WORD_W-1:0] id;
  } tok_t;

endpackage

// ===== src/dbsc_cell.sv =====
// One breakpoint slot cell: holds an entry, appends, compacts and passes the search token on.
module dbsc_cell #(
  parameter int SLOT_IDX = 0,
  parameter int IDX_W = 4,
  parameter int CNT_W = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dbsc_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                  slot_count,
  input  logic [IDX_W-1:0]                  rm_pos,
  input  dbsc_pkg::tok_t                    tok_in,
  input  logic [IDX_W-1:0]                  pos_in,
  input  logic [dbsc_pkg::WORD_W-1:0]       nb_addr,
  input  logic [dbsc_pkg::WORD_W-1:0]       nb_ident,
  output dbsc_pkg::tok_t                    tok_out,
  output logic [IDX_W-1:0]                  pos_out,
  output logic [dbsc_pkg::WORD_W-1:0]       addr_out,
  output logic [dbsc_pkg::WORD_W-1:0]       ident_out
);

  localparam logic [CNT_W-1:0] MY_CNT = CNT_W'(SLOT_IDX);
  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(SLOT_IDX);

  logic [dbsc_pkg::WORD_W-1:0] addr_r, addr_nxt;
  logic [dbsc_pkg::WORD_W-1:0] ident_r, ident_nxt;
  dbsc_pkg::tok_t              tok_r, tok_nxt;
  logic [IDX_W-1:0]            pos_r, pos_nxt;
  logic                        slot_valid;
  logic                        match;

  assign slot_valid = MY_CNT < slot_count;
  assign match = slot_valid &&
                 (ctrl.ident_mode ? (ident_r == ctrl.key) : (addr_r == ctrl.key));

  always_comb begin
    addr_nxt = addr_r;
    ident_nxt = ident_r;
    if (ctrl.load && (slot_count == MY_CNT)) begin
      addr_nxt = ctrl.ld_addr;
      ident_nxt = ctrl.ld_ident;
    end else if (ctrl.shift && (MY_POS >= rm_pos)) begin
      addr_nxt = nb_addr;
      ident_nxt = nb_ident;
    end
  end

  always_comb begin
    tok_nxt = tok_in;
    pos_nxt = pos_in;
    if (!tok_in.found && match) begin
      tok_nxt.found = 1'b1;
      tok_nxt.id = ident_r;
      pos_nxt = MY_POS;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    ident_r <= ident_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
      pos_r <= '0;
    end else begin
      tok_r <= tok_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign tok_out = tok_r;
  assign pos_out = pos_r;
  assign addr_out = addr_r;
  assign ident_out = ident_r;

endmodule

// ===== src/debug_breakpoint_step_control_top.sv =====
// Top level of the debug run-control unit: breakpoint cell row, counters and step control.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_op, in_fetch_pc, in_bp_addr, in_bp_id, | taken when start is high and
//          | in_run_count                            | busy is low
//  result  | out_hit, out_hit_id, out_stop,          | out_valid high for one cycle
//          | out_new_id, out_found, out_list_full    |
//
// Fetch and remove items send a token down the row of BP_SLOTS cells, one cell a cycle,
// and busy is high from when such an item is taken until its result appears. All other
// items give their result in the cycle after they are taken and leave busy low. Reset
// empties the list and clears all counters and the run limit. The receiver cannot stall;
// every result is shown exactly once.
module debug_breakpoint_step_control_top #(
  parameter int BP_SLOTS = dbsc_pkg::BP_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbsc_pkg::OP_W-1:0]     in_op,
  input  logic [dbsc_pkg::WORD_W-1:0]   in_fetch_pc,
  input  logic [dbsc_pkg::WORD_W-1:0]   in_bp_addr,
  input  logic [dbsc_pkg::WORD_W-1:0]   in_bp_id,
  input  logic [dbsc_pkg::CNT_W32-1:0]  in_run_count,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [dbsc_pkg::WORD_W-1:0]   out_hit_id,
  output logic                          out_stop,
  output logic [dbsc_pkg::WORD_W-1:0]   out_new_id,
  output logic                          out_found,
  output logic                          out_list_full
);

  localparam int IDX_W = (BP_SLOTS > 1) ? $clog2(BP_SLOTS) : 1;
  localparam int CNT_W = $clog2(BP_SLOTS + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(BP_SLOTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SEARCH = 1'b1;

  logic                               state_r, state_nxt;
  logic [CNT_W-1:0]                   step_r, step_nxt;
  logic                               mode_r, mode_nxt;
  logic [dbsc_pkg::WORD_W-1:0]        key_r, key_nxt;
  logic [CNT_W-1:0]                   count_r, count_nxt;
  logic [dbsc_pkg::WORD_W-1:0]        next_id_r, next_id_nxt;
  logic [dbsc_pkg::CNT_W32-1:0]       retired_r, retired_nxt;
  logic [dbsc_pkg::CNT_W32-1:0]       target_r, target_nxt;
  logic                               limited_r, limited_nxt;
  logic [dbsc_pkg::WORD_W-1:0]        depth_r, depth_nxt;

  logic                               valid_r, valid_nxt;
  logic                               hit_r, hit_nxt;
  logic [dbsc_pkg::WORD_W-1:0]        hit_id_r, hit_id_nxt;
  logic                               stop_r, stop_nxt;
  logic [dbsc_pkg::WORD_W-1:0]        new_id_r, new_id_nxt;
  logic                               found_r, found_nxt;
  logic                               full_r, full_nxt;

  logic                               accept;
  logic                               load;
  logic                               shift;
  dbsc_pkg::cell_ctrl_t               ctrl;

  dbsc_pkg::tok_t                     tok [BP_SLOTS+1];
  logic [IDX_W-1:0]                   pos [BP_SLOTS+1];
  logic [dbsc_pkg::WORD_W-1:0]        cell_addr [BP_SLOTS];
  logic [dbsc_pkg::WORD_W-1:0]        cell_ident [BP_SLOTS];

  assign accept = start && (state_r == ST_IDLE);
  assign busy = (state_r == ST_SEARCH);

  assign tok[0] = '0;
  assign pos[0] = '0;

  assign ctrl.ident_mode = mode_r;
  assign ctrl.key = key_r;
  assign ctrl.load = load;
  assign ctrl.shift = shift;
  assign ctrl.ld_addr = in_bp_addr;
  assign ctrl.ld_ident = next_id_r;

  for (genvar g = 0; g < BP_SLOTS; g++) begin : g_cell
    logic [dbsc_pkg::WORD_W-1:0] nb_addr;
    logic [dbsc_pkg::WORD_W-1:0] nb_ident;

    if (g == BP_SLOTS - 1) begin : g_last
      assign nb_addr = cell_addr[g];
      assign nb_ident = cell_ident[g];
    end else begin : g_mid
      assign nb_addr = cell_addr[g+1];
      assign nb_ident = cell_ident[g+1];
    end

    dbsc_cell #(
      .SLOT_IDX (g),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .slot_count (count_r),
      .rm_pos     (pos[BP_SLOTS]),
      .tok_in     (tok[g]),
      .pos_in     (pos[g]),
      .nb_addr    (nb_addr),
      .nb_ident   (nb_ident),
      .tok_out    (tok[g+1]),
      .pos_out    (pos[g+1]),
      .addr_out   (cell_addr[g]),
      .ident_out  (cell_ident[g])
    );
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    mode_nxt = mode_r;
    key_nxt = key_r;
    count_nxt = count_r;
    next_id_nxt = next_id_r;
    retired_nxt = retired_r;
    target_nxt = target_r;
    limited_nxt = limited_r;
    depth_nxt = depth_r;
    valid_nxt = 1'b0;
    hit_nxt = 1'b0;
    hit_id_nxt = '0;
    stop_nxt = 1'b0;
    new_id_nxt = '0;
    found_nxt = 1'b0;
    full_nxt = 1'b0;
    load = 1'b0;
    shift = 1'b0;

    if (state_r == ST_SEARCH) begin
      step_nxt = step_r + 1'b1;
      if (step_r == FULL_CNT) begin
        state_nxt = ST_IDLE;
        valid_nxt = 1'b1;
        if (mode_r) begin
          found_nxt = tok[BP_SLOTS].found;
          if (tok[BP_SLOTS].found) begin
            shift = 1'b1;
            count_nxt = count_r - 1'b1;
          end
        end else begin
          hit_nxt = tok[BP_SLOTS].found;
          hit_id_nxt = tok[BP_SLOTS].found ? tok[BP_SLOTS].id : '0;
        end
      end
    end else if (accept) begin
      valid_nxt = 1'b1;
      case (in_op)
        dbsc_pkg::OP_FETCH, dbsc_pkg::OP_REMOVE_BP: begin
          valid_nxt = 1'b0;
          state_nxt = ST_SEARCH;
          step_nxt = '0;
          mode_nxt = (in_op == dbsc_pkg::OP_REMOVE_BP);
          key_nxt = (in_op == dbsc_pkg::OP_REMOVE_BP) ? in_bp_id : in_fetch_pc;
        end
        dbsc_pkg::OP_RETIRE: begin
          retired_nxt = retired_r + 1'b1;
          if (limited_r && ((retired_nxt == target_r) || (depth_r == '0))) begin
            limited_nxt = 1'b0;
            stop_nxt = 1'b1;
          end
        end
        dbsc_pkg::OP_SUB_ENTER: begin
          if (depth_r != dbsc_pkg::WORD_MAX) begin
            depth_nxt = depth_r + 1'b1;
          end
        end
        dbsc_pkg::OP_SUB_EXIT: begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - 1'b1;
          end
        end
        dbsc_pkg::OP_ADD_BP: begin
          if (count_r == FULL_CNT) begin
            full_nxt = 1'b1;
          end else begin
            load = 1'b1;
            new_id_nxt = next_id_r;
            count_nxt = count_r + 1'b1;
            next_id_nxt = next_id_r + 1'b1;
          end
        end
        dbsc_pkg::OP_RUN: begin
          limited_nxt = 1'b0;
        end
        dbsc_pkg::OP_RUN_FOR: begin
          target_nxt = retired_r + in_run_count;
          limited_nxt = 1'b1;
        end
        dbsc_pkg::OP_STEP_OVER: begin
          limited_nxt = 1'b1;
          depth_nxt = '0;
        end
        dbsc_pkg::OP_STEP_OUT: begin
          limited_nxt = 1'b1;
          depth_nxt = dbsc_pkg::WORD_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r <= '0;
      count_r <= '0;
      next_id_r <= '0;
      retired_r <= '0;
      target_r <= '0;
      limited_r <= 1'b0;
      depth_r <= '0;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r <= step_nxt;
      count_r <= count_nxt;
      next_id_r <= next_id_nxt;
      retired_r <= retired_nxt;
      target_r <= target_nxt;
      limited_r <= limited_nxt;
      depth_r <= depth_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r <= mode_nxt;
    key_r <= key_nxt;
    hit_r <= hit_nxt;
    hit_id_r <= hit_id_nxt;
    stop_r <= stop_nxt;
    new_id_r <= new_id_nxt;
    found_r <= found_nxt;
    full_r <= full_nxt;
  end

  assign out_valid = valid_r;
  assign out_hit = hit_r;
  assign out_hit_id = hit_id_r;
  assign out_stop = stop_r;
  assign out_new_id = new_id_r;
  assign out_found = found_r;
  assign out_list_full = full_r;

endmodule
